FILE: design/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int AW      = $clog2(CELLS);

  // Character codes with a meaning of their own
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_BLANK = 8'h20;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_SET   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  // One cell: attribute in the upper byte, character in the lower
  typedef logic [15:0] cell_t;

endpackage

FILE: design/tcw_store.sv
`timescale 1ns / 1ps

module tcw_store import tcw_pkg::*; (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  cell_t         wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output cell_t         rdata_o
);

  cell_t mem [CELLS];
  cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read, data valid the cycle after the request
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/text_console_writer_top.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake                Word
// in       input      in_valid_i / in_ready_o   cmd, data_byte, col, row
// out      output     out_valid_o / out_ready_i cursor_pos/col/row, cell_char/attr
// cfg      input      cfg_we_i, no wait         color attribute byte
//
// One word at a time; in_ready_o is high only while the sequencer is idle.
// Set position, NUL and a newline that needs no scroll go from idle to done.
// Plain character: through the put state. Read cell: through the read state,
// then the read-data state takes the registered store read. Clear screen writes
// every cell, one per cycle through the shared address counter. A scroll copies
// CELLS - COLUMNS cells up, one read and one write per cycle, then blanks the
// bottom row. After reset a clearing pass fills the store with blanks;
// in_ready_o stays low until it ends. cfg writes are taken at any time.
// A stalled result sits in the output register; the next word may be taken
// meanwhile, and a finished word waits in the done state until it is free.

module text_console_writer_top import tcw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  data_byte_i,
  input  logic [6:0]  col_i,
  input  logic [4:0]  row_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [10:0] cursor_pos_o,
  output logic [6:0]  cursor_col_o,
  output logic [4:0]  cursor_row_o,
  output logic [7:0]  cell_char_o,
  output logic [7:0]  cell_attr_o,
  // colour register
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_FILL   = 8'b0000_0010,
    S_SCROLL = 8'b0000_0100,
    S_SCTAIL = 8'b0000_1000,
    S_PUT    = 8'b0001_0000,
    S_READ   = 8'b0010_0000,
    S_RDATA  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  localparam logic [6:0]    COL_LIM   = 7'(COLUMNS);
  localparam logic [6:0]    COL_LAST  = 7'(COLUMNS - 1);
  localparam logic [4:0]    ROW_MAX   = 5'(ROWS - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);
  localparam logic [AW-1:0] BOT_ADDR  = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] COL_ADDR  = AW'(COLUMNS);
  localparam cell_t         BLANK     = {8'h00, CHAR_BLANK};

  state_e        state_q, state_d;
  logic [AW-1:0] addr_q, addr_d;        // shared sweep / source address
  logic [AW-1:0] dst_q, dst_d;          // scroll write address, one behind
  logic          copy_vld_q, copy_vld_d;
  logic          init_q, init_d;
  logic          pend_put_q, pend_put_d;
  cell_t         fill_q, fill_d;
  logic [6:0]    col_q, col_d;
  logic [4:0]    row_q, row_d;
  logic [7:0]    color_q;
  logic [7:0]    data_q, data_d;
  logic [6:0]    req_col_q, req_col_d;
  logic [4:0]    req_row_q, req_row_d;
  logic [7:0]    rd_char_q, rd_char_d;
  logic [7:0]    rd_attr_q, rd_attr_d;

  logic          out_valid_q, out_valid_d;
  logic [10:0]   pos_q, pos_d;
  logic [6:0]    ocol_q, ocol_d;
  logic [4:0]    orow_q, orow_d;
  logic [7:0]    ochar_q, ochar_d;
  logic [7:0]    oattr_q, oattr_d;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  cell_t         mem_wdata, mem_rdata;

  logic [6:0]    lin_col;
  logic [4:0]    lin_row;
  logic [AW-1:0] lin_idx;
  logic          accept;
  logic [4:0]    row_sat;
  logic [6:0]    col_set, col_rd;

  assign accept = in_valid_i && (state_q == S_IDLE);
  assign in_ready_o = (state_q == S_IDLE);

  assign row_sat = (row_i > ROW_MAX)  ? ROW_MAX  : row_i;
  assign col_set = (col_i > COL_LIM)  ? COL_LIM  : col_i;
  assign col_rd  = (col_i > COL_LAST) ? COL_LAST : col_i;

  // shared linear index unit: read position in the read state, else cursor
  assign lin_col = (state_q == S_READ) ? req_col_q : col_q;
  assign lin_row = (state_q == S_READ) ? req_row_q : row_q;
  assign lin_idx = AW'(AW'(lin_row) * COL_ADDR + AW'(lin_col));

  // store port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = fill_q;
    mem_re    = 1'b0;
    mem_raddr = addr_q;
    if (state_q == S_FILL) begin
      mem_we = 1'b1;
    end else if (copy_vld_q) begin
      mem_we    = 1'b1;
      mem_waddr = dst_q;
      mem_wdata = mem_rdata;
    end else if (state_q == S_PUT) begin
      mem_we    = 1'b1;
      mem_waddr = lin_idx;
      mem_wdata = {color_q, data_q};
    end
    if (state_q == S_SCROLL) begin
      mem_re = 1'b1;
    end else if (state_q == S_READ) begin
      mem_re    = 1'b1;
      mem_raddr = lin_idx;
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    dst_d       = dst_q;
    copy_vld_d  = (state_q == S_SCROLL);
    init_d      = init_q;
    pend_put_d  = pend_put_q;
    fill_d      = fill_q;
    col_d       = col_q;
    row_d       = row_q;
    data_d      = data_q;
    req_col_d   = req_col_q;
    req_row_d   = req_row_q;
    rd_char_d   = rd_char_q;
    rd_attr_d   = rd_attr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pos_d       = pos_q;
    ocol_d      = ocol_q;
    orow_d      = orow_q;
    ochar_d     = ochar_q;
    oattr_d     = oattr_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          data_d     = data_byte_i;
          req_col_d  = col_rd;
          req_row_d  = row_sat;
          rd_char_d  = 8'h00;
          rd_attr_d  = 8'h00;
          pend_put_d = 1'b0;
          state_d    = S_DONE;
          case (cmd_e'(cmd_i))
            CMD_PUT: begin
              if (data_byte_i == CHAR_NUL) begin
                state_d = S_DONE;
              end else if (data_byte_i == CHAR_NL || col_q >= COL_LIM) begin
                // start of next row, scrolling from the bottom
                col_d      = 7'd0;
                pend_put_d = (data_byte_i != CHAR_NL);
                if (row_q >= ROW_MAX) begin
                  if (CELLS > COLUMNS) begin
                    addr_d  = COL_ADDR;
                    state_d = S_SCROLL;
                  end else begin
                    addr_d  = BOT_ADDR;
                    fill_d  = BLANK;
                    state_d = S_FILL;
                  end
                end else begin
                  row_d   = row_q + 5'd1;
                  state_d = (data_byte_i == CHAR_NL) ? S_DONE : S_PUT;
                end
              end else begin
                state_d = S_PUT;
              end
            end
            CMD_SET: begin
              col_d   = col_set;
              row_d   = row_sat;
              state_d = S_DONE;
            end
            CMD_CLEAR: begin
              addr_d  = '0;
              fill_d  = {data_byte_i, CHAR_BLANK};
              state_d = S_FILL;
            end
            CMD_READ: begin
              state_d = S_READ;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_FILL: begin
        if (addr_q == LAST_ADDR) begin
          init_d  = 1'b0;
          state_d = init_q ? S_IDLE : (pend_put_q ? S_PUT : S_DONE);
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      S_SCROLL: begin
        dst_d = addr_q - COL_ADDR;
        if (addr_q == LAST_ADDR) begin
          state_d = S_SCTAIL;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      S_SCTAIL: begin
        // last copy write goes out this cycle
        addr_d  = BOT_ADDR;
        fill_d  = BLANK;
        state_d = S_FILL;
      end
      S_PUT: begin
        col_d   = col_q + 7'd1;
        state_d = S_DONE;
      end
      S_READ: begin
        state_d = S_RDATA;
      end
      S_RDATA: begin
        rd_char_d = mem_rdata[7:0];
        rd_attr_d = mem_rdata[15:8];
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          pos_d       = 11'(lin_idx);
          ocol_d      = col_q;
          orow_d      = row_q;
          ochar_d     = rd_char_q;
          oattr_d     = rd_attr_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      addr_q      <= '0;
      copy_vld_q  <= 1'b0;
      init_q      <= 1'b1;
      pend_put_q  <= 1'b0;
      fill_q      <= BLANK;
      col_q       <= 7'd0;
      row_q       <= 5'd0;
      color_q     <= 8'h00;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      copy_vld_q  <= copy_vld_d;
      init_q      <= init_d;
      pend_put_q  <= pend_put_d;
      fill_q      <= fill_d;
      col_q       <= col_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        color_q <= cfg_wdata_i;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    dst_q     <= dst_d;
    data_q    <= data_d;
    req_col_q <= req_col_d;
    req_row_q <= req_row_d;
    rd_char_q <= rd_char_d;
    rd_attr_q <= rd_attr_d;
    pos_q     <= pos_d;
    ocol_q    <= ocol_d;
    orow_q    <= orow_d;
    ochar_q   <= ochar_d;
    oattr_q   <= oattr_d;
  end

  tcw_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign cursor_pos_o = pos_q;
  assign cursor_col_o = ocol_q;
  assign cursor_row_o = orow_q;
  assign cell_char_o  = ochar_q;
  assign cell_attr_o  = oattr_q;

  // checks

  // ready drops after every accepted word
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready held after accept");

  // a printed character advances the column by one
  a_put_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PUT |=> col_q == $past(col_q) + 7'd1)
    else $error("column not advanced after put");

  // copy writes only during and just after the scroll sweep
  a_copy_in_scroll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    copy_vld_q |-> (state_q == S_SCROLL || state_q == S_SCTAIL))
    else $error("copy write outside scroll");

  // reported cursor row on screen, column at most COLUMNS (wrap pending)
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cursor_row_o <= ROW_MAX && cursor_col_o <= COL_LIM))
    else $error("cursor off screen");

endmodule

FILE: verif/tb_text_console_writer_top.sv
`timescale 1ns / 1ps

// Checks the text console against a model of its cell store and cursor.
// Words for put, set position, clear and read go in; each one must bring back
// exactly one cursor report, compared field by field in order.

module tb_text_console_writer_top;
  import tcw_pkg::*;

  // Generous cap: each scroll or clear sweeps the whole store, and there are
  // a few hundred of those at most, plus stalls and the clearing pass after reset.
  localparam int LIMIT_CYCLES = 3000000;
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int PHASE_WORDS  = 238;   // random words per colour setting

  // One console command as it sits on the input channel
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data;
    logic [6:0] col;
    logic [4:0] row;
  } console_word_t;

  // One cursor report as it comes out of the result channel
  typedef struct packed {
    logic [10:0] pos;
    logic [6:0]  col;
    logic [4:0]  row;
    logic [7:0]  ch;
    logic [7:0]  attr;
  } cursor_report_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i       = '0;
  logic [7:0]  data_byte_i = '0;
  logic [6:0]  col_i       = '0;
  logic [4:0]  row_i       = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [10:0] cursor_pos_o;
  logic [6:0]  cursor_col_o;
  logic [4:0]  cursor_row_o;
  logic [7:0]  cell_char_o;
  logic [7:0]  cell_attr_o;
  logic        cfg_we_i    = 1'b0;
  logic [7:0]  cfg_wdata_i = '0;

  // Model state: the screen, the write position and the colour register
  cell_t       screen [CELLS];
  logic [6:0]  cur_col;
  logic [4:0]  cur_row;
  logic [7:0]  attr_reg;

  console_word_t  word_queue [$];        // words still to be offered
  cursor_report_t expected_reports [$];  // reports owed by the block

  logic in_taken    = 1'b0;  // input word accepted at the last rising edge
  logic steady      = 1'b0;  // no random idling on either side
  int   hold_asked  = 0;     // bumped to request a receiver hold-off
  int   hold_done   = 0;
  int   hold_left   = 0;
  int   errors      = 0;
  int   cycle_count = 0;

  text_console_writer_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .data_byte_i  (data_byte_i),
    .col_i        (col_i),
    .row_i        (row_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cursor_pos_o (cursor_pos_o),
    .cursor_col_o (cursor_col_o),
    .cursor_row_o (cursor_row_o),
    .cell_char_o  (cell_char_o),
    .cell_attr_o  (cell_attr_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Console model
  // ---------------------------------------------------------------------------

  // Next row; falling off the bottom scrolls everything up one row and blanks
  // the bottom row, keeping the cursor on the last row.
  function automatic void line_feed();
    int i;
    cur_row = cur_row + 1'b1;
    cur_col = '0;
    if (cur_row >= ROWS) begin
      for (i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
      for (i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = {8'h00, CHAR_BLANK};
      cur_row = 5'(ROWS - 1);
    end
  endfunction

  function automatic cursor_report_t console_apply(console_word_t w);
    cursor_report_t rep;
    int             r;
    int             c;
    int             idx;
    rep = '0;
    r   = (w.row > ROWS - 1) ? ROWS - 1 : w.row;
    case (w.cmd)
      CMD_PUT: begin
        if (w.data == CHAR_NL) begin
          line_feed();
        end else if (w.data != CHAR_NUL) begin
          // wrap pending: move down before printing
          if (cur_col >= COLUMNS) line_feed();
          screen[cur_row * COLUMNS + cur_col] = {attr_reg, w.data};
          cur_col = cur_col + 1'b1;
        end
      end
      CMD_SET: begin
        // column may land on COLUMNS itself (wrap pending)
        cur_col = 7'((w.col > COLUMNS) ? COLUMNS : w.col);
        cur_row = 5'(r);
      end
      CMD_CLEAR: begin
        for (idx = 0; idx < CELLS; idx++) screen[idx] = {w.data, CHAR_BLANK};
      end
      CMD_READ: begin
        c        = (w.col > COLUMNS - 1) ? COLUMNS - 1 : w.col;
        idx      = r * COLUMNS + c;
        rep.ch   = screen[idx][7:0];
        rep.attr = screen[idx][15:8];
      end
    endcase
    rep.pos = 11'(cur_row * COLUMNS + cur_col);
    rep.col = cur_col;
    rep.row = cur_row;
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void queue_word(cmd_e cmd, logic [7:0] data, logic [6:0] col,
                                     logic [4:0] row);
    console_word_t w;
    w.cmd  = cmd;
    w.data = data;
    w.col  = col;
    w.row  = row;
    word_queue.push_back(w);
  endfunction

  // Mostly text with newlines, cursor moves biased to the bottom right so that
  // wraps and scrolls happen often, plus reads, the odd clear and raw noise in
  // the fields a command ignores.
  function automatic console_word_t random_word();
    console_word_t w;
    int unsigned   pick;
    w.cmd  = CMD_PUT;
    w.data = 8'($urandom);
    w.col  = 7'($urandom);
    w.row  = 5'($urandom);
    pick   = $urandom_range(0, 99);
    if (pick < 55) begin
      if ($urandom_range(0, 99) < 85) w.data = 8'($urandom_range(8'h20, 8'h7E));
    end else if (pick < 63) begin
      w.data = CHAR_NL;
    end else if (pick < 65) begin
      w.data = CHAR_NUL;
    end else if (pick < 80) begin
      w.cmd = CMD_SET;
      if ($urandom_range(0, 1) == 1) begin
        w.col = 7'($urandom_range(74, 127));
        w.row = 5'($urandom_range(22, 31));
      end
    end else if (pick < 98) begin
      w.cmd = CMD_READ;
    end else begin
      w.cmd = CMD_CLEAR;
    end
    return w;
  endfunction

  // Colour register write; only done while nothing is in flight
  task automatic set_colour(logic [7:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    attr_reg     = v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Wait until every word is in and every report is out, then a short margin
  task automatic drain();
    while (word_queue.size() != 0 || in_valid_i || expected_reports.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one word held on the input until taken, random gaps between words
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    console_word_t w;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (word_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 9)) begin
        w = word_queue.pop_front();
        in_valid_i  <= 1'b1;
        cmd_i       <= w.cmd;
        data_byte_i <= w.data;
        col_i       <= w.col;
        row_i       <= w.row;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request so the output
  // register and the done state fill up and the input backs off.
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (hold_done != hold_asked) begin
      hold_done   <= hold_asked;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= steady || ($urandom_range(0, 99) >= 9);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check the report leaving this edge, then model the word entering.
  // A report can never leave on the edge its own word enters.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    cursor_report_t want;
    console_word_t  w;
    if (out_valid_o && out_ready_i) begin
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t: report with nothing expected, pos %0d", $time, cursor_pos_o);
      end else begin
        want = expected_reports.pop_front();
        check_field("cursor_pos", 16'(want.pos), 16'(cursor_pos_o));
        check_field("cursor_col", 16'(want.col), 16'(cursor_col_o));
        check_field("cursor_row", 16'(want.row), 16'(cursor_row_o));
        check_field("cell_char", 16'(want.ch), 16'(cell_char_o));
        check_field("cell_attr", 16'(want.attr), 16'(cell_attr_o));
      end
    end
    if (in_valid_i && in_ready_o) begin
      w.cmd  = cmd_e'(cmd_i);
      w.data = data_byte_i;
      w.col  = col_i;
      w.row  = row_i;
      expected_reports.push_back(console_apply(w));
    end
    in_taken <= in_valid_i && in_ready_o;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    int i;
    int p;
    for (i = 0; i < CELLS; i++) screen[i] = {8'h00, CHAR_BLANK};
    cur_col  = '0;
    cur_row  = '0;
    attr_reg = '0;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed corners, printed in the brightest colour
    set_colour(8'hFF);
    queue_word(CMD_READ,  8'h00,      7'd0,   5'd0);   // blank after reset
    queue_word(CMD_PUT,   8'h41,      7'd0,   5'd0);
    queue_word(CMD_PUT,   CHAR_NUL,   7'd127, 5'd31);  // no effect
    queue_word(CMD_PUT,   CHAR_NL,    7'd0,   5'd0);
    queue_word(CMD_READ,  8'h00,      7'd0,   5'd0);
    queue_word(CMD_SET,   8'hFF,      7'd127, 5'd31);  // saturates to wrap pending, bottom
    queue_word(CMD_PUT,   8'h42,      7'd0,   5'd0);   // wrap plus scroll
    queue_word(CMD_READ,  8'h00,      7'd0,   5'd24);
    queue_word(CMD_READ,  8'h00,      7'd127, 5'd31);  // read saturates to last cell
    queue_word(CMD_SET,   8'h00,      7'd79,  5'd24);
    queue_word(CMD_PUT,   8'hFF,      7'd0,   5'd0);   // fills last column
    queue_word(CMD_PUT,   CHAR_NL,    7'd0,   5'd0);   // newline on bottom row scrolls
    queue_word(CMD_READ,  8'h00,      7'd79,  5'd23);
    queue_word(CMD_CLEAR, 8'hFF,      7'd0,   5'd0);
    queue_word(CMD_READ,  8'h00,      7'd40,  5'd12);
    queue_word(CMD_SET,   8'h00,      7'd80,  5'd0);
    queue_word(CMD_PUT,   8'h01,      7'd0,   5'd0);   // wrap without scroll
    queue_word(CMD_READ,  8'h00,      7'd0,   5'd1);
    queue_word(CMD_SET,   8'h00,      7'd0,   5'd0);
    queue_word(CMD_PUT,   8'h7F,      7'd0,   5'd0);
    queue_word(CMD_READ,  8'h00,      7'd0,   5'd0);
    queue_word(CMD_CLEAR, 8'h00,      7'd0,   5'd0);
    queue_word(CMD_READ,  8'h00,      7'd0,   5'd0);
    drain();

    // Random phases, each under its own colour. Phase 1 runs with no idling,
    // phase 3 carries the long receiver hold-off.
    for (p = 0; p < 6; p++) begin
      case (p)
        0:       set_colour(8'h00);
        2:       set_colour(8'hFF);
        default: set_colour(8'($urandom));
      endcase
      steady = (p == 1);
      for (i = 0; i < PHASE_WORDS; i++) word_queue.push_back(random_word());
      if (p == 3) hold_asked++;
      drain();
    end
    steady = 1'b0;

    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
